>>> sv/rgcl_pkg.sv
package rgcl_pkg;

	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int TOTAL_W = 16;
	localparam int SMOOTH_W = 4;
	localparam int WIN_W   = 4;
	localparam int CFG_AW  = 5;
	localparam int CFG_DW  = 32;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_STOP   = 2'd2;
	localparam logic [1:0] MODE_SETTLE = 2'd3;

	localparam logic [2:0] REG_ENTER_LEVEL     = 3'd0;
	localparam logic [2:0] REG_EXIT_LEVEL      = 3'd1;
	localparam logic [2:0] REG_MIN_LAP_MS      = 3'd2;
	localparam logic [2:0] REG_SMOOTHING_LEVEL = 3'd3;
	localparam logic [2:0] REG_FIRST_GATE_BOOT = 3'd4;

	localparam logic [LEVEL_W-1:0]  RELAX_MARGIN     = 8'd4;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX        = 8'd255;
	localparam logic [7:0]          HOLD_MIN         = 8'd2;
	localparam logic [7:0]          HOLD_MAX         = 8'd255;
	localparam logic [TIME_W-1:0]   DRIFT_TIMEOUT_MS = 32'd3000;
	localparam logic [TOTAL_W-1:0]  LAP_TOTAL_MAX    = 16'hFFFF;
	localparam logic [SMOOTH_W-1:0] SMOOTH_MAX       = 4'd10;

	typedef struct packed {
		logic [LEVEL_W-1:0]  enter_level;
		logic [LEVEL_W-1:0]  exit_level;
		logic [15:0]         min_lap_ms;
		logic [SMOOTH_W-1:0] smoothing_level;
		logic                first_gate_bootstrap;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] filtered_level;
		logic               lap_event;
		logic [TIME_W-1:0]  lap_time_ms;
		logic [LEVEL_W-1:0] lap_peak;
		logic [TOTAL_W-1:0] lap_total;
		logic               in_gate;
		logic               race_running;
	} res_t;

	function automatic logic [WIN_W-1:0] window_for_level(input logic [SMOOTH_W-1:0] lv);
		logic [WIN_W-1:0] w;
		unique case (lv)
			4'd0, 4'd1: w = 4'd3;
			4'd2, 4'd3: w = 4'd5;
			4'd4, 4'd5: w = 4'd7;
			4'd6:       w = 4'd9;
			4'd7:       w = 4'd11;
			4'd8, 4'd9: w = 4'd13;
			default:    w = 4'd15;
		endcase
		return w;
	endfunction

endpackage

>>> sv/rssi_gate_crossing_lap_detector_top.sv
// An accepted input passes the input, median and output registers to reach the master side.
// Throughput: one transaction per cycle unless the master stalls; the 15-entry rank median
// and the detector each take one registered stage, and the output register frees the input side.
// Reset (arst_n low, asynchronous): race stopped, median empty, lap total zero,
// configuration registers at their defaults, pipeline emptied.
module rssi_gate_crossing_lap_detector_top #(
	parameter int MAX_MEDIAN_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // raw_level[7:0], time_ms[39:8]
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // filtered_level[7:0], lap_event[8], lap_time_ms[40:9],
	                                    // lap_peak[48:41], lap_total[64:49], in_gate[65],
	                                    // race_running[66], zeros[71:67]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [rgcl_pkg::CFG_AW-1:0] paddr,
	input  logic [rgcl_pkg::CFG_DW-1:0] pwdata,
	output logic [rgcl_pkg::CFG_DW-1:0] prdata,
	output logic        pready
);
	import rgcl_pkg::*;

	cfg_t cfg;

	logic               valid_s1, valid_s2, out_valid_q;
	logic [1:0]         mode_s1, mode_s2;
	logic [LEVEL_W-1:0] raw_s1, filt_s2;
	logic [TIME_W-1:0]  time_s1, time_s2;
	logic               full_s2;
	res_t               res_q, res_d;

	logic               out_ready, s2_ok, s1_ok, fire1, fire2;
	logic [LEVEL_W-1:0] med_filt;
	logic               med_full;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign fire2         = valid_s2 && out_ready;
	assign s2_ok         = !valid_s2 || out_ready;
	assign fire1         = valid_s1 && s2_ok;
	assign s1_ok         = !valid_s1 || s2_ok;
	assign s_axis_tready = s1_ok;
	assign m_axis_tvalid = out_valid_q;

	rgcl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rgcl_median #(
		.MAXW (MAX_MEDIAN_WINDOW)
	) u_median (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (fire1 && (mode_s1 == MODE_SAMPLE)),
		.clear           (fire1 && (mode_s1 == MODE_START)),
		.raw             (raw_s1),
		.smoothing_level (cfg.smoothing_level),
		.filt            (med_filt),
		.full            (med_full)
	);

	rgcl_detect u_detect (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire2),
		.mode    (mode_s2),
		.filt    (filt_s2),
		.full    (full_s2),
		.time_ms (time_s2),
		.cfg     (cfg),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ok) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_ok) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s1_ok) begin
			mode_s1 <= s_axis_tuser;
			raw_s1  <= s_axis_tdata[7:0];
			time_s1 <= s_axis_tdata[39:8];
		end
		if (fire1) begin
			mode_s2 <= mode_s1;
			filt_s2 <= med_filt;
			full_s2 <= med_full;
			time_s2 <= time_s1;
		end
		if (fire2) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tdata = {5'd0, res_q.race_running, res_q.in_gate, res_q.lap_total,
		res_q.lap_peak, res_q.lap_time_ms, res_q.lap_event, res_q.filtered_level};

endmodule

>>> sv/rgcl_cfg_regs.sv
module rgcl_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rgcl_pkg::CFG_AW-1:0]   paddr,
	input  logic [rgcl_pkg::CFG_DW-1:0]   pwdata,
	output logic [rgcl_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	output rgcl_pkg::cfg_t                cfg
);
	import rgcl_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_level          <= 8'd120;
			cfg_q.exit_level           <= 8'd100;
			cfg_q.min_lap_ms           <= 16'd5000;
			cfg_q.smoothing_level      <= 4'd5;
			cfg_q.first_gate_bootstrap <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ENTER_LEVEL:     cfg_q.enter_level          <= pwdata[7:0];
				REG_EXIT_LEVEL:      cfg_q.exit_level           <= pwdata[7:0];
				REG_MIN_LAP_MS:      cfg_q.min_lap_ms           <= pwdata[15:0];
				REG_SMOOTHING_LEVEL: cfg_q.smoothing_level      <= pwdata[3:0];
				REG_FIRST_GATE_BOOT: cfg_q.first_gate_bootstrap <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ENTER_LEVEL:     prdata = {24'd0, cfg_q.enter_level};
			REG_EXIT_LEVEL:      prdata = {24'd0, cfg_q.exit_level};
			REG_MIN_LAP_MS:      prdata = {16'd0, cfg_q.min_lap_ms};
			REG_SMOOTHING_LEVEL: prdata = {28'd0, cfg_q.smoothing_level};
			REG_FIRST_GATE_BOOT: prdata = {31'd0, cfg_q.first_gate_bootstrap};
			default:             prdata = '0;
		endcase
	end

endmodule

>>> sv/rgcl_median.sv
module rgcl_median #(
	parameter int MAXW = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            clear,
	input  logic [rgcl_pkg::LEVEL_W-1:0]    raw,
	input  logic [rgcl_pkg::SMOOTH_W-1:0]   smoothing_level,
	output logic [rgcl_pkg::LEVEL_W-1:0]    filt,
	output logic                            full
);
	import rgcl_pkg::*;

	localparam int IW = $clog2(MAXW);
	localparam int CW = $clog2(MAXW + 1);

	logic [LEVEL_W-1:0] store_q [MAXW];
	logic [IW-1:0]      slot_q;
	logic [CW-1:0]      fill_q;

	logic [SMOOTH_W-1:0] lv;
	logic [CW-1:0]       win_n;
	logic [CW-1:0]       fill_new;
	logic [CW-1:0]       avail;
	logic [CW-1:0]       mid;
	logic [IW-1:0]       slot_next;
	logic [LEVEL_W-1:0]  val [MAXW];
	logic [IW-1:0]       age [MAXW];
	logic [MAXW-1:0]     incl;
	logic [CW-1:0]       rank [MAXW];
	int                  win_i;

	always_comb begin
		lv    = (smoothing_level > SMOOTH_MAX) ? SMOOTH_MAX : smoothing_level;
		win_i = int'(window_for_level(lv));
		win_n = (win_i > MAXW) ? CW'(MAXW) : CW'(win_i);
		fill_new  = (fill_q < CW'(MAXW)) ? fill_q + CW'(1) : fill_q;
		full      = (fill_new >= win_n);
		avail     = (fill_new < win_n) ? fill_new : win_n;
		mid       = avail >> 1;
		slot_next = (slot_q == IW'(MAXW - 1)) ? '0 : slot_q + IW'(1);
	end

	always_comb begin
		for (int k = 0; k < MAXW; k++) begin
			val[k] = (slot_q == IW'(k)) ? raw : store_q[k];
			if (slot_q >= IW'(k)) begin
				age[k] = slot_q - IW'(k);
			end else begin
				age[k] = slot_q + IW'(MAXW) - IW'(k);
			end
			incl[k] = (CW'(age[k]) < avail);
		end
	end

	always_comb begin
		for (int k = 0; k < MAXW; k++) begin
			rank[k] = '0;
			for (int j = 0; j < MAXW; j++) begin
				if (incl[j] && ((val[j] < val[k]) || ((val[j] == val[k]) && (j < k)))) begin
					rank[k] = rank[k] + CW'(1);
				end
			end
		end
	end

	always_comb begin
		filt = '0;
		for (int k = 0; k < MAXW; k++) begin
			if (incl[k] && (rank[k] == mid)) begin
				filt = filt | val[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (clear) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			slot_q <= slot_next;
			fill_q <= fill_new;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[slot_q] <= raw;
		end
	end

endmodule

>>> sv/rgcl_detect.sv
module rgcl_detect (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [1:0]                    mode,
	input  logic [rgcl_pkg::LEVEL_W-1:0]  filt,
	input  logic                          full,
	input  logic [rgcl_pkg::TIME_W-1:0]   time_ms,
	input  rgcl_pkg::cfg_t                cfg,
	output rgcl_pkg::res_t                res
);
	import rgcl_pkg::*;

	logic               running_q, first_pending_q, boot_armed_q, cross_q;
	logic [7:0]         hold_cnt_q;
	logic [TIME_W-1:0]  hold_start_q, peak_time_q, lap_start_q, race_start_q;
	logic [LEVEL_W-1:0] peak_q;
	logic [TOTAL_W-1:0] laps_q;

	logic               running_n, first_pending_n, boot_armed_n, cross_n;
	logic [7:0]         hold_cnt_n;
	logic [TIME_W-1:0]  hold_start_n, peak_time_n, lap_start_n, race_start_n;
	logic [LEVEL_W-1:0] peak_n;
	logic [TOTAL_W-1:0] laps_n;

	logic               can_go, start_set, lap_ev;
	logic [LEVEL_W-1:0] relaxed, eff, lpeak;
	logic [TIME_W-1:0]  ref_ms, delta, ltime;

	always_comb begin
		running_n       = running_q;
		first_pending_n = first_pending_q;
		boot_armed_n    = boot_armed_q;
		cross_n         = cross_q;
		hold_cnt_n      = hold_cnt_q;
		hold_start_n    = hold_start_q;
		peak_n          = peak_q;
		peak_time_n     = peak_time_q;
		lap_start_n     = lap_start_q;
		race_start_n    = race_start_q;
		laps_n          = laps_q;
		can_go          = 1'b0;
		start_set       = 1'b0;
		lap_ev          = 1'b0;
		lpeak           = '0;
		ltime           = '0;
		ref_ms          = '0;
		delta           = '0;
		relaxed = (cfg.exit_level >= LEVEL_MAX - RELAX_MARGIN) ? LEVEL_MAX
			: cfg.exit_level + RELAX_MARGIN;
		eff = cfg.enter_level;

		unique case (mode)
			MODE_START: begin
				laps_n          = '0;
				first_pending_n = 1'b1;
				race_start_n    = time_ms;
				lap_start_n     = time_ms;
				running_n       = 1'b1;
				boot_armed_n    = 1'b0;
				cross_n         = 1'b0;
				peak_n          = '0;
				peak_time_n     = '0;
				hold_cnt_n      = '0;
				hold_start_n    = '0;
			end
			MODE_STOP: begin
				running_n    = 1'b0;
				lap_start_n  = '0;
				boot_armed_n = 1'b0;
				cross_n      = 1'b0;
				peak_n       = '0;
				peak_time_n  = '0;
				hold_cnt_n   = '0;
				hold_start_n = '0;
			end
			MODE_SAMPLE: begin
				if (running_q && full) begin
					priority if (cfg.first_gate_bootstrap && first_pending_q) begin
						if (!boot_armed_q) begin
							boot_armed_n = 1'b1;
							cross_n      = 1'b0;
							peak_n       = '0;
							peak_time_n  = '0;
							hold_cnt_n   = '0;
							hold_start_n = '0;
							if (filt >= cfg.enter_level) begin
								cross_n      = 1'b1;
								peak_n       = filt;
								peak_time_n  = time_ms;
								hold_cnt_n   = HOLD_MIN;
								hold_start_n = time_ms;
							end
						end
						can_go = 1'b1;
					end else if (first_pending_q) begin
						can_go = 1'b1;
					end else begin
						can_go = ((time_ms - lap_start_q) >= {16'd0, cfg.min_lap_ms});
					end

					if (can_go) begin
						if (first_pending_n && boot_armed_n && (relaxed < eff)) begin
							eff = relaxed;
						end
						if (filt >= eff) begin
							start_set = cross_n || (hold_cnt_n != 8'd0);
							if (hold_cnt_n < HOLD_MAX) begin
								hold_cnt_n = hold_cnt_n + 8'd1;
							end
							if (!start_set) begin
								hold_start_n = time_ms;
							end
							if (hold_cnt_n >= HOLD_MIN) begin
								cross_n = 1'b1;
								if (filt > peak_n) begin
									peak_n      = filt;
									peak_time_n = time_ms;
								end
							end
							if (cross_n && ((time_ms - hold_start_n) > DRIFT_TIMEOUT_MS)) begin
								cross_n      = 1'b0;
								peak_n       = '0;
								peak_time_n  = '0;
								hold_cnt_n   = '0;
								hold_start_n = '0;
							end
						end else begin
							hold_cnt_n = '0;
							if (!cross_n) begin
								hold_start_n = '0;
							end
						end

						if (cross_n && (filt < cfg.exit_level)) begin
							if (peak_n == '0) begin
								cross_n = 1'b0;
							end else begin
								ref_ms = first_pending_n ? race_start_q : lap_start_q;
								delta  = peak_time_n - ref_ms;
								ltime  = ((delta == '0) || delta[TIME_W-1]) ? '0 : delta;
								lpeak  = peak_n;
								lap_ev = 1'b1;
								first_pending_n = 1'b0;
								if (laps_q < LAP_TOTAL_MAX) begin
									laps_n = laps_q + 16'd1;
								end
								lap_start_n  = peak_time_n;
								cross_n      = 1'b0;
								peak_n       = '0;
								peak_time_n  = '0;
								hold_cnt_n   = '0;
								hold_start_n = '0;
							end
						end
					end
				end
			end
			default: ;
		endcase

		res.filtered_level = (mode == MODE_SAMPLE) ? filt : '0;
		res.lap_event      = lap_ev;
		res.lap_time_ms    = ltime;
		res.lap_peak       = lpeak;
		res.lap_total      = laps_n;
		res.in_gate        = cross_n;
		res.race_running   = running_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q       <= 1'b0;
			first_pending_q <= 1'b1;
			boot_armed_q    <= 1'b0;
			cross_q         <= 1'b0;
			hold_cnt_q      <= '0;
			hold_start_q    <= '0;
			peak_q          <= '0;
			peak_time_q     <= '0;
			lap_start_q     <= '0;
			race_start_q    <= '0;
			laps_q          <= '0;
		end else if (fire) begin
			running_q       <= running_n;
			first_pending_q <= first_pending_n;
			boot_armed_q    <= boot_armed_n;
			cross_q         <= cross_n;
			hold_cnt_q      <= hold_cnt_n;
			hold_start_q    <= hold_start_n;
			peak_q          <= peak_n;
			peak_time_q     <= peak_time_n;
			lap_start_q     <= lap_start_n;
			race_start_q    <= race_start_n;
			laps_q          <= laps_n;
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rgcl_pkg::*;

	class lap_scoreboard;
		localparam int STORE_DEPTH = 15;
		localparam int RELAX_LEVELS = 4;
		localparam int HOLD_SAMPLES = 2;
		localparam logic [31:0] DRIFT_LIMIT_MS = 32'd3000;

		int win_by_level[11] = '{3, 3, 5, 5, 7, 7, 9, 11, 13, 13, 15};

		logic [7:0]  enter_lvl;
		logic [7:0]  exit_lvl;
		logic [15:0] min_lap;
		logic [3:0]  smooth;
		bit          boot_en;

		logic [7:0]  store[STORE_DEPTH];
		int          fill;
		int          wr_slot;
		bit          running;
		bit          first_pending;
		bit          boot_armed;
		bit          crossing;
		logic [7:0]  hold_cnt;
		logic [31:0] hold_start;
		logic [7:0]  peak_lvl;
		logic [31:0] peak_t;
		logic [31:0] lap_start;
		logic [31:0] race_start;
		logic [15:0] laps;

		res_t exp_q[$];
		int   errors;

		function new();
			enter_lvl = 8'd120;
			exit_lvl = 8'd100;
			min_lap = 16'd5000;
			smooth = 4'd5;
			boot_en = 0;
			foreach (store[i])
				store[i] = '0;
			fill = 0;
			wr_slot = 0;
			running = 0;
			first_pending = 1;
			boot_armed = 0;
			clear_crossing();
			lap_start = '0;
			race_start = '0;
			laps = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_ENTER_LEVEL:     enter_lvl = val[7:0];
				REG_EXIT_LEVEL:      exit_lvl = val[7:0];
				REG_MIN_LAP_MS:      min_lap = val[15:0];
				REG_SMOOTHING_LEVEL: smooth = val[3:0];
				REG_FIRST_GATE_BOOT: boot_en = val[0];
				default: ;
			endcase
		endfunction

		function int window_len();
			int n;
			n = win_by_level[(smooth > 4'd10) ? 10 : int'(smooth)];
			return (n > STORE_DEPTH) ? STORE_DEPTH : n;
		endfunction

		function int pending();
			return exp_q.size();
		endfunction

		function void clear_crossing();
			crossing = 0;
			peak_lvl = '0;
			peak_t = '0;
			hold_cnt = '0;
			hold_start = '0;
		endfunction

		function logic [7:0] median_push(logic [7:0] raw, output bit full);
			logic [7:0] srt[STORE_DEPTH];
			logic [7:0] v;
			int n, avail, j, slot;
			n = window_len();
			store[wr_slot] = raw;
			wr_slot = (wr_slot + 1) % STORE_DEPTH;
			if (fill < STORE_DEPTH)
				fill++;
			full = (fill >= n);
			avail = (fill < n) ? fill : n;
			for (int i = 0; i < avail; i++) begin
				slot = (wr_slot + STORE_DEPTH - 1 - i) % STORE_DEPTH;
				v = store[slot];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			return srt[avail / 2];
		endfunction

		function void track_crossing(logic [7:0] lvl, logic [31:0] t);
			int eff, relaxed;
			bit start_set;
			eff = enter_lvl;
			relaxed = (exit_lvl >= 8'd251) ? 255 : int'(exit_lvl) + RELAX_LEVELS;
			if (first_pending && boot_armed && relaxed < eff)
				eff = relaxed;
			if (int'(lvl) >= eff) begin
				start_set = crossing || (hold_cnt != 0);
				if (hold_cnt < 8'd255)
					hold_cnt++;
				if (!start_set)
					hold_start = t;
				if (hold_cnt >= HOLD_SAMPLES) begin
					crossing = 1;
					if (lvl > peak_lvl) begin
						peak_lvl = lvl;
						peak_t = t;
					end
				end
				if (crossing && (t - hold_start) > DRIFT_LIMIT_MS)
					clear_crossing();
			end else begin
				hold_cnt = '0;
				if (!crossing)
					hold_start = '0;
			end
		endfunction

		function void note_input(logic [1:0] mode, logic [7:0] raw, logic [31:0] t);
			res_t r;
			bit full, can;
			logic [7:0] filt;
			logic [31:0] lap_ref, d;
			r = '0;
			case (mode)
				MODE_START: begin
					fill = 0;
					wr_slot = 0;
					foreach (store[i])
						store[i] = '0;
					laps = '0;
					first_pending = 1;
					race_start = t;
					lap_start = t;
					running = 1;
					boot_armed = 0;
					clear_crossing();
				end
				MODE_STOP: begin
					running = 0;
					lap_start = '0;
					boot_armed = 0;
					clear_crossing();
				end
				MODE_SAMPLE: begin
					filt = median_push(raw, full);
					r.filtered_level = filt;
					if (running && full) begin
						if (boot_en && first_pending) begin
							if (!boot_armed) begin
								boot_armed = 1;
								clear_crossing();
								if (filt >= enter_lvl) begin
									crossing = 1;
									peak_lvl = filt;
									peak_t = t;
									hold_cnt = HOLD_SAMPLES;
									hold_start = t;
								end
							end
							can = 1;
						end else if (first_pending) begin
							can = 1;
						end else begin
							can = ((t - lap_start) >= {16'd0, min_lap});
						end
						if (can) begin
							track_crossing(filt, t);
							if (crossing && filt < exit_lvl) begin
								if (peak_lvl == 0) begin
									crossing = 0;
								end else begin
									lap_ref = first_pending ? race_start : lap_start;
									d = peak_t - lap_ref;
									r.lap_time_ms = (d == 0 || d[31]) ? 32'd0 : d;
									r.lap_peak = peak_lvl;
									r.lap_event = 1;
									first_pending = 0;
									if (laps != 16'hFFFF)
										laps++;
									lap_start = peak_t;
									clear_crossing();
								end
							end
						end
					end
				end
				default: ;
			endcase
			r.lap_total = laps;
			r.in_gate = crossing;
			r.race_running = running;
			exp_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [71:0] d);
			res_t e;
			if (exp_q.size() == 0) begin
				errors++;
				$display("%0t: result expected none actual %h", $time, d);
				return;
			end
			e = exp_q.pop_front();
			compare_field("filtered_level", e.filtered_level, d[7:0]);
			compare_field("lap_event", e.lap_event, d[8]);
			compare_field("lap_time_ms", e.lap_time_ms, d[40:9]);
			compare_field("lap_peak", e.lap_peak, d[48:41]);
			compare_field("lap_total", e.lap_total, d[64:49]);
			compare_field("in_gate", e.in_gate, d[65]);
			compare_field("race_running", e.race_running, d[66]);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [39:0]        s_axis_tdata;   // raw_level[7:0], time_ms[39:8]
	logic [1:0]         s_axis_tuser;   // mode[1:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [71:0]        m_axis_tdata;   // filtered_level, lap_event, lap_time_ms, lap_peak,
	                                    // lap_total, in_gate, race_running, zeros
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [CFG_AW-1:0]  paddr;
	logic [CFG_DW-1:0]  pwdata;
	logic [CFG_DW-1:0]  prdata;
	logic               pready;

	lap_scoreboard sb = new();
	int          src_idle_pct = 22;
	int          sink_idle_pct = 22;
	bit          hold_req = 0;
	int          items_sent = 0;
	logic [31:0] t_now = '0;

	rssi_gate_crossing_lap_detector_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin : sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		m_axis_tready <= 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else if (hold_req && !hold_done) begin
				hold_left = 300;
				hold_done = 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_cfg(int enter, int exit_v, int min_ms, int smooth_v, int boot);
		write_reg(REG_ENTER_LEVEL, enter);
		write_reg(REG_EXIT_LEVEL, exit_v);
		write_reg(REG_MIN_LAP_MS, min_ms);
		write_reg(REG_SMOOTHING_LEVEL, smooth_v);
		write_reg(REG_FIRST_GATE_BOOT, boot);
	endtask

	task automatic send_item(logic [1:0] mode, logic [7:0] raw, logic [31:0] t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {t, raw};
		s_axis_tuser <= mode;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		sb.note_input(mode, raw, t);
		if (mode != MODE_SETTLE)
			items_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] low_level();
		return (sb.exit_lvl == 0) ? 8'd0 : 8'($urandom_range(sb.exit_lvl - 1, 0));
	endfunction

	function automatic logic [7:0] high_level();
		int floor_lvl;
		floor_lvl = sb.enter_lvl;
		if (sb.exit_lvl <= 8'd250 && sb.exit_lvl + 4 < floor_lvl)
			floor_lvl = sb.exit_lvl + 4;
		return 8'($urandom_range(255, floor_lvl));
	endfunction

	task automatic race_pass();
		int n_lo, n_hi, n_tail, win;
		int unsigned hi_step;
		win = sb.window_len();
		n_lo = $urandom_range(6, 0);
		n_hi = $urandom_range(win + 6, 1);
		n_tail = $urandom_range(win + 3, 1);
		hi_step = ($urandom_range(99) < 15) ? $urandom_range(1200, 400) : $urandom_range(150, 5);
		t_now += $urandom_range(9000, 0);
		repeat (n_lo) begin
			t_now += $urandom_range(400, 5);
			send_item(MODE_SAMPLE, low_level(), t_now);
		end
		repeat (n_hi) begin
			t_now += hi_step;
			send_item(MODE_SAMPLE, high_level(), t_now);
		end
		repeat (n_tail) begin
			t_now += $urandom_range(200, 5);
			send_item(MODE_SAMPLE, low_level(), t_now);
		end
	endtask

	task automatic run_phase(int quota, bit with_start);
		int goal, pick;
		goal = items_sent + quota;
		if (with_start) begin
			t_now += $urandom_range(500, 1);
			send_item(MODE_START, 8'($urandom), t_now);
		end
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(MODE_START, 8'($urandom), t_now);
			end else if (pick < 8) begin
				t_now += $urandom_range(300, 0);
				send_item(MODE_STOP, 8'($urandom), t_now);
			end else if (pick < 11) begin
				send_item(MODE_SETTLE, 8'($urandom), $urandom);
			end else if (pick < 16) begin
				if ($urandom_range(3) == 0)
					t_now = $urandom;
				else
					t_now += $urandom_range(400, 0);
				send_item(MODE_SAMPLE, 8'($urandom_range(255)), t_now);
			end else begin
				race_pass();
			end
		end
	endtask

	initial begin : stimulus
		arst_n <= 0;
		s_axis_tvalid <= 0;
		s_axis_tdata <= '0;
		s_axis_tuser <= MODE_SAMPLE;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		set_cfg(120, 100, 0, 0, 0);
		send_item(MODE_SETTLE, 8'd255, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, 8'd0, 32'd0);
		send_item(MODE_SAMPLE, 8'd255, 32'd1);
		send_item(MODE_STOP, 8'd0, 32'd2);
		send_item(MODE_START, 8'd0, 32'd1000);
		send_item(MODE_SAMPLE, 8'd255, 32'd1010);
		send_item(MODE_SAMPLE, 8'd255, 32'd1020);
		send_item(MODE_SAMPLE, 8'd255, 32'd1030);
		send_item(MODE_SAMPLE, 8'd255, 32'd1040);
		send_item(MODE_SAMPLE, 8'd0, 32'd1050);
		send_item(MODE_SAMPLE, 8'd0, 32'd1060);
		send_item(MODE_START, 8'd0, 32'd5000);
		repeat (4) send_item(MODE_SAMPLE, 8'd200, 32'd5000);
		repeat (2) send_item(MODE_SAMPLE, 8'd0, 32'd5000);
		send_item(MODE_SETTLE, 8'd0, 32'd0);
		send_item(MODE_STOP, 8'd255, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, 8'd17, 32'h8000_0000);
		drain_results();

		set_cfg(120, 100, 2000, 2, 0);
		run_phase(80, 1);
		drain_results();

		set_cfg(200, 150, 0, 0, 1);
		run_phase(80, 1);
		drain_results();

		set_cfg(255, 255, 65535, 10, 1);
		run_phase(80, 1);
		drain_results();

		set_cfg(0, 0, 0, 15, 0);
		run_phase(70, 1);
		drain_results();

		set_cfg(140, 60, 1500, 5, 1);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		hold_req = 1;
		run_phase(90, 1);
		drain_results();
		src_idle_pct = 22;
		sink_idle_pct = 22;

		write_reg(REG_SMOOTHING_LEVEL, 8);
		write_reg(REG_MIN_LAP_MS, 300);
		run_phase(80, 0);
		drain_results();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
sv/rgcl_pkg.sv
sv/rgcl_cfg_regs.sv
sv/rgcl_median.sv
sv/rgcl_detect.sv
sv/rssi_gate_crossing_lap_detector_top.sv
bench/tb_top.sv
